/* rtl/sao_pkg.sv */
package sao_pkg;

	localparam int CW     = 36;   // internal point coordinate width
	localparam int LW     = 34;   // segment length width
	localparam int UW     = 31;   // unit vector magnitude width, Q1.30
	localparam int PW     = 66;   // raw product width
	localparam int RAD_W  = 65;   // squared length width
	localparam int NUM_W  = 63;   // divider numerator width
	localparam int SQ_N   = 34;   // square root stages, one root bit each
	localparam int DV_N   = UW;   // divider stages, one quotient bit each
	localparam int NV     = 11;   // most vertices per segment
	localparam int NCW    = 4;    // vertex count width

	localparam logic [UW-1:0] ONE_Q30 = UW'(1) << 30;

	localparam logic [1:0] HEAD_SINGLE = 2'd0;
	localparam logic [1:0] HEAD_REV    = 2'd1;
	localparam logic [1:0] HEAD_DOUBLE = 2'd2;

	localparam logic [1:0] BODY_PLAIN = 2'd0;
	localparam logic [1:0] BODY_LEFT  = 2'd1;
	localparam logic [1:0] BODY_RIGHT = 2'd2;

	typedef enum logic [2:0] {
		REG_HEAD_KIND   = 3'd0,
		REG_BODY_KIND   = 3'd1,
		REG_START_WIDTH = 3'd2,
		REG_BODY_WIDTH  = 3'd3,
		REG_HEAD_LENGTH = 3'd4,
		REG_HEAD_THICK  = 3'd5,
		REG_SIDE_OFFSET = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic [31:0]        adx;
		logic [31:0]        ady;
		logic               sx;
		logic               sy;
		logic [LW-1:0]      len;
	} trk_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} pt_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} vtx_t;

endpackage

/* rtl/sao_seg_if.sv */
interface sao_seg_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] dest_x;
	logic signed [31:0] dest_y;

	modport source(output valid, output origin_x, output origin_y, output dest_x,
		output dest_y, input ready);
	modport sink(input valid, input origin_x, input origin_y, input dest_x,
		input dest_y, output ready);
endinterface

/* rtl/sao_vtx_if.sv */
interface sao_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic               is_last;

	modport source(output valid, output vertex_x, output vertex_y, output is_last,
		input ready);
	modport sink(input valid, input vertex_x, input vertex_y, input is_last,
		output ready);
endinterface

/* rtl/straight_arrow_outline_top.sv */
// Straight arrow outline generator.
// seg (sink) takes one segment per item: origin and destination, signed Q16.16.
// vtx (source) returns the closed outline of the arrow, one vertex per item,
// saturated to signed Q16.16; is_last marks the closing vertex, which repeats
// the first. A segment yields 3 to 11 vertices depending on head and body kind.
// The configuration port writes one register per cycle at cfg_idx when cfg_we
// is high; write it only while no segment is in flight.
// Pipeline: a segment passes through a 78 stage pipeline (length square root one
// bit per stage, unit vector division one bit per stage, then stretch, offset and
// vertex maths) before its first vertex is offered.
// The output shift register sends one vertex per cycle while vtx is ready, so a
// segment holds it for as many vertices as it yields; segments overlap in the pipe.
// When vtx stalls, the shift register holds, the whole pipeline freezes once a
// finished outline waits behind it, and seg.ready drops; nothing is lost.
// Reset clears all valid bits, empties the output and restores the register
// defaults; no clearing pass is needed.
module straight_arrow_outline_top import sao_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_data,
	sao_seg_if.sink     seg,
	sao_vtx_if.source   vtx
);

	localparam int P_O = 0;
	localparam int P_Q = 1;
	localparam int P_A = 2;
	localparam int P_B = 3;
	localparam int P_C = 4;
	localparam int P_D = 5;
	localparam int P_E = 6;
	localparam int P_F = 7;
	localparam int P_G = 8;
	localparam int P_H = 9;
	localparam int P_I = 10;
	localparam int P_J = 11;
	localparam int P_K = 12;
	localparam int P_L = 13;
	localparam int NCAND = 14;

	function automatic logic signed [CW-1:0] rnd(input logic [PW-1:0] p, input logic sh31,
		input logic neg);
		logic [PW-1:0]        m;
		logic signed [CW-1:0] mc;
		m  = sh31 ? ((p + (PW'(1) << 30)) >> 31) : ((p + (PW'(1) << 29)) >> 30);
		mc = m[CW-1:0];
		return neg ? -mc : mc;
	endfunction

	function automatic logic signed [31:0] sat(input logic signed [CW-1:0] v);
		if (v > CW'(32'sh7fff_ffff))
			return 32'sh7fff_ffff;
		else if (v < -(CW'(1) <<< 31))
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	// configuration registers
	logic [1:0]         head_kind_q, body_kind_q;
	logic [23:0]        start_width_q, body_width_q, head_len_q, head_thk_q;
	logic signed [23:0] side_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_kind_q   <= HEAD_SINGLE;
			body_kind_q   <= BODY_PLAIN;
			start_width_q <= 24'd65536;
			body_width_q  <= 24'd65536;
			head_len_q    <= 24'd98304;
			head_thk_q    <= 24'd98304;
			side_off_q    <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_HEAD_KIND:   head_kind_q   <= cfg_data[1:0];
				REG_BODY_KIND:   body_kind_q   <= cfg_data[1:0];
				REG_START_WIDTH: start_width_q <= cfg_data;
				REG_BODY_WIDTH:  body_width_q  <= cfg_data;
				REG_HEAD_LENGTH: head_len_q    <= cfg_data;
				REG_HEAD_THICK:  head_thk_q    <= cfg_data;
				REG_SIDE_OFFSET: side_off_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [1:0]  hk;
	logic        right, left;
	logic        so_neg;
	logic [23:0] so_mag;

	assign hk     = (head_kind_q == 2'd3) ? HEAD_SINGLE : head_kind_q;
	assign right  = (body_kind_q == BODY_PLAIN) || (body_kind_q == BODY_RIGHT);
	assign left   = (body_kind_q == BODY_PLAIN) || (body_kind_q == BODY_LEFT);
	assign so_neg = side_off_q[23];
	assign so_mag = so_neg ? 24'(-side_off_q) : side_off_q;

	logic adv, load, fire;

	assign seg.ready = adv;

	// stage 1: capture
	logic               v_s1;
	logic signed [31:0] ox_s1, oy_s1, qx_s1, qy_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ox_s1 <= seg.origin_x;
			oy_s1 <= seg.origin_y;
			qx_s1 <= seg.dest_x;
			qy_s1 <= seg.dest_y;
		end
	end

	// stage 2: differences and magnitudes
	logic        v_s2;
	trk_t        trk_s2;
	logic [32:0] dx, dy, ndx, ndy;

	assign dx  = {qx_s1[31], qx_s1} - {ox_s1[31], ox_s1};
	assign dy  = {qy_s1[31], qy_s1} - {oy_s1[31], oy_s1};
	assign ndx = 33'd0 - dx;
	assign ndy = 33'd0 - dy;

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s2.ox  <= ox_s1;
			trk_s2.oy  <= oy_s1;
			trk_s2.qx  <= qx_s1;
			trk_s2.qy  <= qy_s1;
			trk_s2.sx  <= dx[32];
			trk_s2.sy  <= dy[32];
			trk_s2.adx <= dx[32] ? ndx[31:0] : dx[31:0];
			trk_s2.ady <= dy[32] ? ndy[31:0] : dy[31:0];
			trk_s2.len <= '0;
		end
	end

	// stage 3: squares
	logic        v_s3;
	trk_t        trk_s3;
	logic [63:0] sqx_s3, sqy_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s3 <= trk_s2;
			sqx_s3 <= 64'(trk_s2.adx) * 64'(trk_s2.adx);
			sqy_s3 <= 64'(trk_s2.ady) * 64'(trk_s2.ady);
		end
	end

	// stage 4: squared length
	logic             v_s4;
	trk_t             trk_s4;
	logic [RAD_W-1:0] rad_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s4 <= trk_s3;
			rad_s4 <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
		end
	end

	// square root, with the segment travelling alongside
	logic [LW-1:0]   sq_root;
	trk_t            sq_trk [SQ_N];
	logic [SQ_N-1:0] sq_v;

	sao_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s4),
		.root (sq_root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_trk[0] <= trk_s4;
			for (int k = 1; k < SQ_N; k++)
				sq_trk[k] <= sq_trk[k-1];
		end
	end

	// stage 5: rounded numerators
	logic             v_s5;
	trk_t             trk_s5;
	trk_t             nxt_trk5;
	logic [NUM_W-1:0] nx_s5, ny_s5;

	always_comb begin
		nxt_trk5     = sq_trk[SQ_N-1];
		nxt_trk5.len = sq_root;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s5 <= nxt_trk5;
			nx_s5  <= NUM_W'({sq_trk[SQ_N-1].adx, 30'd0}) + NUM_W'(sq_root >> 1);
			ny_s5  <= NUM_W'({sq_trk[SQ_N-1].ady, 30'd0}) + NUM_W'(sq_root >> 1);
		end
	end

	// unit vector division
	logic [UW-1:0]   qx_dv, qy_dv;
	trk_t            dv_trk [DV_N];
	logic [DV_N-1:0] dv_v;

	sao_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (nx_s5),
		.den (trk_s5.len),
		.quo (qx_dv)
	);

	sao_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (ny_s5),
		.den (trk_s5.len),
		.quo (qy_dv)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_trk[0] <= trk_s5;
			for (int k = 1; k < DV_N; k++)
				dv_trk[k] <= dv_trk[k-1];
		end
	end

	// stage 6: unit vector, zero length falls back to +x
	logic          v_s6;
	trk_t          trk_s6;
	trk_t          nxt_trk6;
	logic [UW-1:0] umx_s6, umy_s6;
	logic          zero_len;

	assign zero_len = (dv_trk[DV_N-1].len == '0);

	always_comb begin
		nxt_trk6 = dv_trk[DV_N-1];
		if (zero_len) begin
			nxt_trk6.sx = 1'b0;
			nxt_trk6.sy = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s6 <= nxt_trk6;
			umx_s6 <= zero_len ? ONE_Q30 : qx_dv;
			umy_s6 <= zero_len ? '0 : qy_dv;
		end
	end

	// stage 7: head and offset products, midpoint, short segment tests
	logic               v_s7;
	trk_t               trk_s7;
	logic [UW-1:0]      umx_s7, umy_s7;
	logic [PW-1:0]      hpx_s7, hpy_s7, spx_s7, spy_s7;
	logic               snx_s7, sny_s7, short1_s7, short2_s7;
	logic signed [31:0] mx_s7, my_s7;
	logic [32:0]        sum_x, sum_y;

	assign sum_x = {trk_s6.ox[31], trk_s6.ox} + {trk_s6.qx[31], trk_s6.qx};
	assign sum_y = {trk_s6.oy[31], trk_s6.oy} + {trk_s6.qy[31], trk_s6.qy};

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s7    <= trk_s6;
			umx_s7    <= umx_s6;
			umy_s7    <= umy_s6;
			hpx_s7    <= PW'(head_len_q) * PW'(umx_s6);
			hpy_s7    <= PW'(head_len_q) * PW'(umy_s6);
			spx_s7    <= PW'(so_mag) * PW'(umy_s6);
			spy_s7    <= PW'(so_mag) * PW'(umx_s6);
			snx_s7    <= so_neg ^ ~trk_s6.sy;
			sny_s7    <= so_neg ^ trk_s6.sx;
			mx_s7     <= sum_x[32:1];
			my_s7     <= sum_y[32:1];
			short1_s7 <= trk_s6.len < LW'(head_len_q);
			short2_s7 <= trk_s6.len < LW'({head_len_q, 1'b0});
		end
	end

	// stage 8: round head and offset vectors
	logic                 v_s8;
	trk_t                 trk_s8;
	logic [UW-1:0]        umx_s8, umy_s8;
	logic signed [CW-1:0] hux_s8, huy_s8, sox_s8, soy_s8;
	logic signed [31:0]   mx_s8, my_s8;
	logic                 short1_s8, short2_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s8    <= trk_s7;
			umx_s8    <= umx_s7;
			umy_s8    <= umy_s7;
			hux_s8    <= rnd(hpx_s7, 1'b0, trk_s7.sx);
			huy_s8    <= rnd(hpy_s7, 1'b0, trk_s7.sy);
			sox_s8    <= rnd(spx_s7, 1'b0, snx_s7);
			soy_s8    <= rnd(spy_s7, 1'b0, sny_s7);
			mx_s8     <= mx_s7;
			my_s8     <= my_s7;
			short1_s8 <= short1_s7;
			short2_s8 <= short2_s7;
		end
	end

	// stage 9: stretch short segments, shift sideways, body length
	logic                 v_s9;
	logic [UW-1:0]        umx_s9, umy_s9;
	logic                 sx_s9, sy_s9;
	logic signed [CW-1:0] ox_s9, oy_s9, qx_s9, qy_s9;
	logic [LW-1:0]        b_s9;
	logic signed [CW-1:0] so_x, so_y, sq_x, sq_y, mxw, myw;
	logic [LW-1:0]        l2;

	always_comb begin
		so_x = CW'(trk_s8.ox);
		so_y = CW'(trk_s8.oy);
		sq_x = CW'(trk_s8.qx);
		sq_y = CW'(trk_s8.qy);
		mxw  = CW'(mx_s8);
		myw  = CW'(my_s8);
		l2   = trk_s8.len;
		case (hk)
			HEAD_DOUBLE: begin
				if (short2_s8) begin
					so_x = mxw - hux_s8;
					so_y = myw - huy_s8;
					sq_x = mxw + hux_s8;
					sq_y = myw + huy_s8;
					l2   = LW'({head_len_q, 1'b0});
				end
			end
			HEAD_REV: begin
				if (short1_s8) begin
					sq_x = CW'(trk_s8.ox) + hux_s8;
					sq_y = CW'(trk_s8.oy) + huy_s8;
					l2   = LW'(head_len_q);
				end
			end
			default: begin
				if (short1_s8) begin
					so_x = CW'(trk_s8.qx) - hux_s8;
					so_y = CW'(trk_s8.qy) - huy_s8;
					l2   = LW'(head_len_q);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			umx_s9 <= umx_s8;
			umy_s9 <= umy_s8;
			sx_s9  <= trk_s8.sx;
			sy_s9  <= trk_s8.sy;
			ox_s9  <= so_x + sox_s8;
			oy_s9  <= so_y + soy_s8;
			qx_s9  <= sq_x + sox_s8;
			qy_s9  <= sq_y + soy_s8;
			b_s9   <= l2 - LW'(head_len_q);
		end
	end

	// stage 10: vertex offset products
	logic                 v_s10;
	logic                 sx_s10, sy_s10;
	logic signed [CW-1:0] ox_s10, oy_s10, qx_s10, qy_s10;
	logic [PW-1:0]        phx_s10, phy_s10, pbx_s10, pby_s10, ptx_s10, pty_s10;
	logic [PW-1:0]        pwx_s10, pwy_s10, psx_s10, psy_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s10  <= sx_s9;
			sy_s10  <= sy_s9;
			ox_s10  <= ox_s9;
			oy_s10  <= oy_s9;
			qx_s10  <= qx_s9;
			qy_s10  <= qy_s9;
			phx_s10 <= PW'(head_len_q) * PW'(umx_s9);
			phy_s10 <= PW'(head_len_q) * PW'(umy_s9);
			pbx_s10 <= PW'(b_s9) * PW'(umx_s9);
			pby_s10 <= PW'(b_s9) * PW'(umy_s9);
			ptx_s10 <= PW'(head_thk_q) * PW'(umy_s9);
			pty_s10 <= PW'(head_thk_q) * PW'(umx_s9);
			pwx_s10 <= PW'(body_width_q) * PW'(umy_s9);
			pwy_s10 <= PW'(body_width_q) * PW'(umx_s9);
			psx_s10 <= PW'(start_width_q) * PW'(umy_s9);
			psy_s10 <= PW'(start_width_q) * PW'(umx_s9);
		end
	end

	// stage 11: round; widths are halved in the rounding shift
	logic                 v_s11;
	logic signed [CW-1:0] ox_s11, oy_s11, qx_s11, qy_s11;
	logic signed [CW-1:0] hux_s11, huy_s11, bux_s11, buy_s11, tpx_s11, tpy_s11;
	logic signed [CW-1:0] wpx_s11, wpy_s11, spx_s11, spy_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			ox_s11  <= ox_s10;
			oy_s11  <= oy_s10;
			qx_s11  <= qx_s10;
			qy_s11  <= qy_s10;
			hux_s11 <= rnd(phx_s10, 1'b0, sx_s10);
			huy_s11 <= rnd(phy_s10, 1'b0, sy_s10);
			bux_s11 <= rnd(pbx_s10, 1'b0, sx_s10);
			buy_s11 <= rnd(pby_s10, 1'b0, sy_s10);
			tpx_s11 <= rnd(ptx_s10, 1'b0, ~sy_s10);
			tpy_s11 <= rnd(pty_s10, 1'b0, sx_s10);
			wpx_s11 <= rnd(pwx_s10, 1'b1, ~sy_s10);
			wpy_s11 <= rnd(pwy_s10, 1'b1, sx_s10);
			spx_s11 <= rnd(psx_s10, 1'b1, ~sy_s10);
			spy_s11 <= rnd(psy_s10, 1'b1, sx_s10);
		end
	end

	// stage 12: every candidate vertex
	logic v_s12;
	pt_t  cand_s12 [NCAND];

	always_ff @(posedge clk) begin
		if (adv) begin
			cand_s12[P_O].x <= ox_s11;
			cand_s12[P_O].y <= oy_s11;
			cand_s12[P_Q].x <= qx_s11;
			cand_s12[P_Q].y <= qy_s11;
			cand_s12[P_A].x <= ox_s11 + hux_s11 + tpx_s11;
			cand_s12[P_A].y <= oy_s11 + huy_s11 + tpy_s11;
			cand_s12[P_B].x <= ox_s11 + hux_s11 + wpx_s11;
			cand_s12[P_B].y <= oy_s11 + huy_s11 + wpy_s11;
			cand_s12[P_C].x <= ox_s11 + bux_s11 + wpx_s11;
			cand_s12[P_C].y <= oy_s11 + buy_s11 + wpy_s11;
			cand_s12[P_D].x <= ox_s11 + bux_s11 + tpx_s11;
			cand_s12[P_D].y <= oy_s11 + buy_s11 + tpy_s11;
			cand_s12[P_E].x <= ox_s11 + bux_s11 - tpx_s11;
			cand_s12[P_E].y <= oy_s11 + buy_s11 - tpy_s11;
			cand_s12[P_F].x <= ox_s11 + bux_s11 - wpx_s11;
			cand_s12[P_F].y <= oy_s11 + buy_s11 - wpy_s11;
			cand_s12[P_G].x <= ox_s11 + hux_s11 - wpx_s11;
			cand_s12[P_G].y <= oy_s11 + huy_s11 - wpy_s11;
			cand_s12[P_H].x <= ox_s11 + hux_s11 - tpx_s11;
			cand_s12[P_H].y <= oy_s11 + huy_s11 - tpy_s11;
			cand_s12[P_I].x <= ox_s11 + spx_s11;
			cand_s12[P_I].y <= oy_s11 + spy_s11;
			cand_s12[P_J].x <= ox_s11 - spx_s11;
			cand_s12[P_J].y <= oy_s11 - spy_s11;
			cand_s12[P_K].x <= qx_s11 + spx_s11;
			cand_s12[P_K].y <= qy_s11 + spy_s11;
			cand_s12[P_L].x <= qx_s11 - spx_s11;
			cand_s12[P_L].y <= qy_s11 - spy_s11;
		end
	end

	// stage 13: saturate and order the outline
	logic           v_s13;
	vtx_t           lst_s13 [NV];
	logic [NCW-1:0] n_s13;
	vtx_t           sv [NCAND];
	vtx_t           lst [NV];
	logic [NCW-1:0] n;

	always_comb begin
		for (int k = 0; k < NCAND; k++) begin
			sv[k].x = sat(cand_s12[k].x);
			sv[k].y = sat(cand_s12[k].y);
		end
	end

	always_comb begin
		n = '0;
		for (int k = 0; k < NV; k++)
			lst[k] = '0;
		case (hk)
			HEAD_DOUBLE: begin
				lst[n] = sv[P_O]; n = n + NCW'(1);
				if (right) begin
					lst[n] = sv[P_A]; n = n + NCW'(1);
					lst[n] = sv[P_B]; n = n + NCW'(1);
					lst[n] = sv[P_C]; n = n + NCW'(1);
					lst[n] = sv[P_D]; n = n + NCW'(1);
				end
				lst[n] = sv[P_Q]; n = n + NCW'(1);
				if (left) begin
					lst[n] = sv[P_E]; n = n + NCW'(1);
					lst[n] = sv[P_F]; n = n + NCW'(1);
					lst[n] = sv[P_G]; n = n + NCW'(1);
					lst[n] = sv[P_H]; n = n + NCW'(1);
				end
			end
			HEAD_REV: begin
				lst[n] = sv[P_O]; n = n + NCW'(1);
				if (right) begin
					lst[n] = sv[P_A]; n = n + NCW'(1);
					lst[n] = sv[P_B]; n = n + NCW'(1);
					lst[n] = sv[P_K]; n = n + NCW'(1);
				end else begin
					lst[n] = sv[P_Q]; n = n + NCW'(1);
				end
				if (left) begin
					lst[n] = sv[P_L]; n = n + NCW'(1);
					lst[n] = sv[P_G]; n = n + NCW'(1);
					lst[n] = sv[P_H]; n = n + NCW'(1);
				end else begin
					lst[n] = sv[P_Q]; n = n + NCW'(1);
				end
			end
			default: begin
				if (right) begin
					lst[n] = sv[P_I]; n = n + NCW'(1);
					lst[n] = sv[P_C]; n = n + NCW'(1);
					lst[n] = sv[P_D]; n = n + NCW'(1);
				end else begin
					lst[n] = sv[P_O]; n = n + NCW'(1);
				end
				lst[n] = sv[P_Q]; n = n + NCW'(1);
				if (left) begin
					lst[n] = sv[P_E]; n = n + NCW'(1);
					lst[n] = sv[P_F]; n = n + NCW'(1);
					lst[n] = sv[P_J]; n = n + NCW'(1);
				end else begin
					lst[n] = sv[P_O]; n = n + NCW'(1);
				end
			end
		endcase
		// close the polygon
		lst[n] = lst[0];
		n = n + NCW'(1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lst_s13 <= lst;
			n_s13   <= n;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			sq_v  <= '0;
			v_s5  <= 1'b0;
			dv_v  <= '0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s1  <= seg.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			sq_v  <= {sq_v[SQ_N-2:0], v_s4};
			v_s5  <= sq_v[SQ_N-1];
			dv_v  <= {dv_v[DV_N-2:0], v_s5};
			v_s6  <= dv_v[DV_N-1];
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// output shift register
	vtx_t           ser_q [NV];
	logic [NCW-1:0] cnt_q;

	assign fire = vtx.valid && vtx.ready;
	assign load = v_s13 && ((cnt_q == '0) || (fire && (cnt_q == NCW'(1))));
	assign adv  = !v_s13 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (load)
			cnt_q <= n_s13;
		else if (fire)
			cnt_q <= cnt_q - NCW'(1);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ser_q <= lst_s13;
		end else if (fire) begin
			for (int k = 0; k < NV - 1; k++)
				ser_q[k] <= ser_q[k+1];
		end
	end

	assign vtx.valid    = (cnt_q != '0);
	assign vtx.vertex_x = ser_q[0].x;
	assign vtx.vertex_y = ser_q[0].y;
	assign vtx.is_last  = (cnt_q == NCW'(1));

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NCW'(NV))
		else $error("vertex count beyond outline size");

	a_list_len: assert property (@(posedge clk) disable iff (!arst_n)
		v_s13 |-> (n_s13 >= NCW'(3)) && (n_s13 <= NCW'(NV)))
		else $error("outline list length out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vtx.valid && !vtx.ready |=> $stable(cnt_q) && $stable(ser_q[0]))
		else $error("output vertex moved while stalled");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s13) && $stable(n_s13))
		else $error("pipeline advanced while frozen");

endmodule

/* rtl/sao_isqrt.sv */
module sao_isqrt import sao_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [RAD_W-1:0] rad,
	output logic [LW-1:0]    root
);

	localparam int RDW = 2 * SQ_N;

	logic [RDW-1:0]  rad_s  [SQ_N];
	logic [LW+1:0]   rem_s  [SQ_N];
	logic [LW-1:0]   root_s [SQ_N];

	for (genvar g = 0; g < SQ_N; g++) begin : g_stage
		logic [RDW-1:0] rad_i;
		logic [LW+1:0]  rem_i;
		logic [LW-1:0]  root_i;
		logic [LW+3:0]  r2;
		logic [LW+3:0]  trial;
		logic [LW+3:0]  diff;
		logic           ge;

		if (g == 0) begin : g_first
			assign rad_i  = {{(RDW-RAD_W){1'b0}}, rad};
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_next
			assign rad_i  = rad_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign root_i = root_s[g-1];
		end

		// bring down the next pair of radicand bits and try a one in this root bit
		assign r2    = {rem_i, rad_i[RDW-1 -: 2]};
		assign trial = {2'b00, root_i, 2'b01};
		assign diff  = r2 - trial;
		assign ge    = (r2 >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g]  <= rad_i << 2;
				rem_s[g]  <= ge ? diff[LW+1:0] : r2[LW+1:0];
				root_s[g] <= {root_i[LW-2:0], ge};
			end
		end
	end

	assign root = root_s[SQ_N-1];

endmodule

/* rtl/sao_div.sv */
module sao_div import sao_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [LW-1:0]    den,
	output logic [UW-1:0]    quo
);

	logic [LW-1:0] rem_s [DV_N];
	logic [LW-1:0] den_s [DV_N];
	logic [UW-1:0] low_s [DV_N];
	logic [UW-1:0] quo_s [DV_N];

	for (genvar g = 0; g < DV_N; g++) begin : g_stage
		logic [LW-1:0] rem_i;
		logic [LW-1:0] den_i;
		logic [UW-1:0] low_i;
		logic [UW-1:0] quo_i;
		logic [LW:0]   r2;
		logic [LW:0]   diff;
		logic          ge;

		if (g == 0) begin : g_first
			// quotient stays below 2^UW, so the top bits start below the divisor
			assign rem_i = LW'(num[NUM_W-1:UW]);
			assign den_i = den;
			assign low_i = num[UW-1:0];
			assign quo_i = '0;
		end else begin : g_next
			assign rem_i = rem_s[g-1];
			assign den_i = den_s[g-1];
			assign low_i = low_s[g-1];
			assign quo_i = quo_s[g-1];
		end

		assign r2   = {rem_i, low_i[UW-1]};
		assign diff = r2 - {1'b0, den_i};
		assign ge   = (r2 >= {1'b0, den_i});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= ge ? diff[LW-1:0] : r2[LW-1:0];
				den_s[g] <= den_i;
				low_s[g] <= low_i << 1;
				quo_s[g] <= {quo_i[UW-2:0], ge};
			end
		end
	end

	assign quo = quo_s[DV_N-1];

endmodule
